FILE: rtl/core/bdeq_pkg.sv
package bdeq_pkg;

    localparam int unsigned VALUE_W = 32;

    // operation codes carried in the kind field
    localparam logic [2:0] K_PUSH_FRONT = 3'd0;
    localparam logic [2:0] K_PUSH_BACK  = 3'd1;
    localparam logic [2:0] K_POP_FRONT  = 3'd2;
    localparam logic [2:0] K_POP_BACK   = 3'd3;
    localparam logic [2:0] K_TRAVERSE   = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef logic signed [VALUE_W-1:0] t_word;

    typedef struct packed {
        logic [2:0] kind;
        t_word      value;
    } t_in_item;

    typedef struct packed {
        t_word      value_res;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // one command broadcast to every cell of the row
    typedef struct packed {
        logic shift_right;
        logic push_back;
        logic shift_left;
        logic pop_back;
        logic rotate;
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_TRAV
    } t_state;

endpackage

FILE: rtl/core/bdeq_cell.sv
module bdeq_cell
    import bdeq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cell_op i_op,
    input  t_word    i_value,
    input  t_word    i_head,
    input  t_word    i_left_data,
    input  logic     i_left_valid,
    input  t_word    i_right_data,
    input  logic     i_right_valid,
    output t_word    o_data,
    output logic     o_valid,
    output logic     o_back
);

    t_word r_data;
    t_word n_data;
    logic  r_valid;
    logic  n_valid;
    logic  is_back;

    assign is_back = r_valid && !i_right_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_op.shift_right) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_op.push_back && i_left_valid && !r_valid) begin
            n_data  = i_value;
            n_valid = 1'b1;
        end else if (i_op.shift_left) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_op.pop_back && is_back) begin
            n_valid = 1'b0;
        end else if (i_op.rotate && r_valid) begin
            // back cell wraps the front element around
            n_data = i_right_valid ? i_right_data : i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_back  = is_back;

endmodule

FILE: rtl/core/bounded_double_ended_queue_core.sv
// Channel  | Direction | Handshake             | Payload
// command  | in        | start high, busy low  | i_item (kind, value)
// result   | out       | o_res_strobe, 1 cycle | o_res (value_res, status, last)
//
// Push, pop and an unknown kind never raise busy; push and pop put their beat out in the
// cycle after start, an unknown kind gives no beat.
// Traverse emits one element per cycle from the front cell while the row rotates;
// busy drops with the last beat, the row is back in order at the end.
// Synchronous active-low reset empties the row; element storage is not cleared.
// Results cannot be stalled.
module bounded_double_ended_queue_core
    import bdeq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_res_strobe,
    output t_out_item o_res
);

    localparam int CW = $clog2(DEPTH + 1);

    t_word    cell_data  [DEPTH];
    logic     cell_valid [DEPTH];
    logic     cell_back  [DEPTH];
    logic [DEPTH-1:0] valid_vec;
    t_word    back_value;
    t_cell_op cell_op;

    t_state    r_state;
    t_state    n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;
    logic      r_strobe;
    logic      n_strobe;
    t_out_item r_res;
    t_out_item n_res;

    logic accept;
    logic is_empty;
    logic is_full;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_word left_data;
            logic  left_valid;
            t_word right_data;
            logic  right_valid;
            if (g == 0) begin : g_first
                assign left_data  = i_item.value;
                assign left_valid = 1'b1;
            end else begin : g_mid
                assign left_data  = cell_data[g-1];
                assign left_valid = cell_valid[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign right_data  = '0;
                assign right_valid = 1'b0;
            end else begin : g_inner
                assign right_data  = cell_data[g+1];
                assign right_valid = cell_valid[g+1];
            end
            bdeq_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_op          (cell_op),
                .i_value       (i_item.value),
                .i_head        (cell_data[0]),
                .i_left_data   (left_data),
                .i_left_valid  (left_valid),
                .i_right_data  (right_data),
                .i_right_valid (right_valid),
                .o_data        (cell_data[g]),
                .o_valid       (cell_valid[g]),
                .o_back        (cell_back[g])
            );
            assign valid_vec[g] = cell_valid[g];
        end
    endgenerate

    // at most one cell flags itself as back, so an OR of masked words selects it
    always_comb begin
        back_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            back_value = back_value | (cell_data[i] & {VALUE_W{cell_back[i]}});
        end
    end

    assign is_empty = !cell_valid[0];
    assign is_full  = cell_valid[DEPTH-1];
    assign accept   = start && (r_state == S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_item.kind == K_TRAVERSE && !is_empty
                        && r_count != CW'(1)) begin
                    n_state = S_TRAV;
                end
            end
            S_TRAV: begin
                if (r_idx == r_count - CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        cell_op  = '0;
        n_count  = r_count;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_res    = '{value_res: '0, status: STAT_OK, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.kind)
                        K_PUSH_FRONT, K_PUSH_BACK: begin
                            n_strobe = 1'b1;
                            if (is_full) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                cell_op.shift_right = (i_item.kind == K_PUSH_FRONT);
                                cell_op.push_back   = (i_item.kind == K_PUSH_BACK);
                                n_count = r_count + CW'(1);
                            end
                        end
                        K_POP_FRONT, K_POP_BACK: begin
                            n_strobe = 1'b1;
                            if (is_empty) begin
                                n_res.status = STAT_EMPTY;
                            end else begin
                                cell_op.shift_left = (i_item.kind == K_POP_FRONT);
                                cell_op.pop_back   = (i_item.kind == K_POP_BACK);
                                n_res.value_res = (i_item.kind == K_POP_FRONT)
                                                  ? cell_data[0] : back_value;
                                n_count = r_count - CW'(1);
                            end
                        end
                        K_TRAVERSE: begin
                            n_strobe = 1'b1;
                            if (is_empty) begin
                                n_res.status = STAT_EMPTY;
                            end else begin
                                cell_op.rotate  = 1'b1;
                                n_res.value_res = cell_data[0];
                                n_res.last      = (r_count == CW'(1));
                                n_idx           = CW'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TRAV: begin
                cell_op.rotate  = 1'b1;
                n_strobe        = 1'b1;
                n_res.value_res = cell_data[0];
                n_res.last      = (r_idx == r_count - CW'(1));
                n_idx           = r_idx + CW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign busy         = (r_state == S_TRAV);
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    // occupied cells always match the element count
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == 32'(r_count))
        else $error("cell valid bits disagree with element count");

    // traverse never stays busy with fewer than two elements in the row
    a_trav_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_count > CW'(1)))
        else $error("traverse active with fewer than two elements");

    // every recognized command yields a beat in the next cycle
    a_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.kind == K_PUSH_FRONT || i_item.kind == K_PUSH_BACK
            || i_item.kind == K_POP_FRONT || i_item.kind == K_POP_BACK
            || i_item.kind == K_TRAVERSE)) |=> o_res_strobe)
        else $error("command produced no result");

    // the final beat of a command coincides with the block going free
    a_last_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.last) |-> !busy)
        else $error("last beat while still busy");

endmodule

FILE: bench/bounded_double_ended_queue_core_test.sv
`timescale 1ns / 1ps

module bounded_double_ended_queue_core_test;
    import bdeq_pkg::*;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int N_PHASES = 4;
    localparam int PHASE_ITEMS = 18;
    localparam int DRAIN_LIMIT = 20000;

    typedef struct {
        t_in_item  item;
        bit        fixed_exp;
        t_out_item want;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  cmd_item;
    logic      busy;
    logic      res_strobe;
    t_out_item res_item;

    // typed expectation that rides along with the command being offered
    logic      dir_fixed;
    t_out_item dir_want;

    // predictor copy of the ring
    t_word            dq_slots [DEPTH];
    logic [IDX_W-1:0] dq_front;
    logic [IDX_W:0]   dq_count;

    t_out_item pending_res[$];
    t_dir_row  dir_rows[$];

    int n_err;
    int n_cmds;
    int n_results;
    int n_trav;
    int n_full;
    int n_empty;
    int ph;
    int cnt;
    int cyc;
    t_in_item nxt;

    int idle_pct [N_PHASES] = '{0, 45, 15, 0};
    int push_w   [N_PHASES] = '{45, 20, 70, 40};
    int pop_w    [N_PHASES] = '{35, 65, 15, 40};

    bounded_double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_item      (cmd_item),
        .busy        (busy),
        .o_res_strobe(res_strobe),
        .o_res       (res_item)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial begin
        #1_000_000;
        $display("bounded_double_ended_queue_core verification failed");
        $finish;
    end

    // work out the results of one accepted command and advance the ring
    task automatic deque_apply(input t_in_item it);
        t_out_item r;
        t_out_item res[$];
        r = '0;
        r.last = 1'b1;
        case (it.kind)
            K_PUSH_FRONT, K_PUSH_BACK: begin
                if (dq_count == DEPTH) begin
                    r.status = STAT_FULL;
                end else if (it.kind == K_PUSH_FRONT) begin
                    dq_front = dq_front - 1'b1;
                    dq_slots[dq_front] = it.value;
                    dq_count++;
                end else begin
                    dq_slots[IDX_W'(dq_front + dq_count)] = it.value;
                    dq_count++;
                end
                res.push_back(r);
            end
            K_POP_FRONT, K_POP_BACK: begin
                if (dq_count == 0) begin
                    r.status = STAT_EMPTY;
                end else if (it.kind == K_POP_FRONT) begin
                    r.value_res = dq_slots[dq_front];
                    dq_front = dq_front + 1'b1;
                    dq_count--;
                end else begin
                    r.value_res = dq_slots[IDX_W'(dq_front + dq_count - 1)];
                    dq_count--;
                end
                res.push_back(r);
            end
            K_TRAVERSE: begin
                n_trav++;
                if (dq_count == 0) begin
                    r.status = STAT_EMPTY;
                    res.push_back(r);
                end else begin
                    for (int i = 0; i < dq_count; i++) begin
                        r.value_res = dq_slots[IDX_W'(dq_front + i)];
                        r.last = (i == dq_count - 1);
                        res.push_back(r);
                    end
                end
            end
            default: ;  // unused kinds: no result
        endcase
        if (dir_fixed) begin
            pending_res.push_back(dir_want);
        end else begin
            foreach (res[i]) pending_res.push_back(res[i]);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            n_cmds++;
            deque_apply(cmd_item);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && res_strobe !== 1'b0) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected beat: value_res %0d status %0d last %0d",
                         $time, res_item.value_res, res_item.status, res_item.last);
                n_err++;
            end else begin
                want = pending_res.pop_front();
                n_results++;
                if (res_item.status === STAT_FULL) n_full++;
                if (res_item.status === STAT_EMPTY) n_empty++;
                if (res_item.value_res !== want.value_res) begin
                    $display("%0t: value_res expected %0d, got %0d",
                             $time, want.value_res, res_item.value_res);
                    n_err++;
                end
                if (res_item.status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, res_item.status);
                    n_err++;
                end
                if (res_item.last !== want.last) begin
                    $display("%0t: last expected %0d, got %0d",
                             $time, want.last, res_item.last);
                    n_err++;
                end
            end
        end
    end

    // start stays high from one beat to the next unless an idle gap is drawn
    task automatic send_cmd(input t_in_item it, input bit fixed, input t_out_item want,
                            input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        cmd_item  <= it;
        dir_fixed <= fixed;
        dir_want  <= want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic add_row(input logic [2:0] k, input t_word v, input bit fixed,
                           input t_word ev, input logic [1:0] est);
        t_dir_row row;
        row.item.kind       = k;
        row.item.value      = v;
        row.fixed_exp       = fixed;
        row.want.value_res  = ev;
        row.want.status     = est;
        row.want.last       = 1'b1;
        dir_rows.push_back(row);
    endtask

    function automatic t_word pick_value();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item pick_cmd(input int pw, input int qw);
        t_in_item it;
        int r;
        r = $urandom_range(99);
        it.value = pick_value();
        if (r < pw) begin
            it.kind = $urandom_range(1) ? K_PUSH_BACK : K_PUSH_FRONT;
        end else if (r < pw + qw) begin
            it.kind = $urandom_range(1) ? K_POP_BACK : K_POP_FRONT;
        end else if (r < 94) begin
            it.kind = K_TRAVERSE;
        end else begin
            it.kind = 3'($urandom_range(7, 5));
        end
        return it;
    endfunction

    initial begin
        i_rst_n   = 1'b0;
        start     = 1'b0;
        cmd_item  = '0;
        dir_fixed = 1'b0;
        dir_want  = '0;
        dq_front  = '0;
        dq_count  = '0;
        n_err     = 0;
        n_cmds    = 0;
        n_results = 0;
        n_trav    = 0;
        n_full    = 0;
        n_empty   = 0;

        // empty queue after reset
        add_row(K_POP_FRONT, 32'sd5, 1'b1, '0, STAT_EMPTY);
        add_row(K_POP_BACK, -32'sd5, 1'b1, '0, STAT_EMPTY);
        add_row(K_TRAVERSE, '0, 1'b1, '0, STAT_EMPTY);
        // value extremes, then pop back leaves a single element queue empty
        add_row(K_PUSH_BACK, 32'sh7FFF_FFFF, 1'b1, '0, STAT_OK);
        add_row(K_PUSH_FRONT, 32'sh8000_0000, 1'b1, '0, STAT_OK);
        add_row(K_TRAVERSE, '0, 1'b0, '0, STAT_OK);
        add_row(K_POP_FRONT, '0, 1'b1, 32'sh8000_0000, STAT_OK);
        add_row(K_POP_BACK, '0, 1'b1, 32'sh7FFF_FFFF, STAT_OK);
        add_row(3'd7, 32'sd1, 1'b0, '0, STAT_OK);
        // fill to capacity from both ends, so the front wraps
        for (int i = 0; i < DEPTH; i++) begin
            add_row((i % 2) ? K_PUSH_FRONT : K_PUSH_BACK,
                    t_word'(32'h1357_9BDF * (i + 1)), 1'b0, '0, STAT_OK);
        end
        add_row(K_PUSH_BACK, 32'sd99, 1'b1, '0, STAT_FULL);
        add_row(K_TRAVERSE, '0, 1'b0, '0, STAT_OK);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_cmd(dir_rows[i].item, dir_rows[i].fixed_exp, dir_rows[i].want, 0);
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            cnt = 0;
            while (cnt < PHASE_ITEMS) begin
                nxt = pick_cmd(push_w[ph], pop_w[ph]);
                send_cmd(nxt, 1'b0, '0, idle_pct[ph]);
                if (nxt.kind <= K_TRAVERSE) cnt++;
            end
            if (ph == 1) begin
                // hold off until the queue of expected beats runs dry
                start <= 1'b0;
                do @(posedge i_clk); while (pending_res.size() != 0);
            end
        end

        start <= 1'b0;
        cyc = 0;
        do begin
            @(posedge i_clk);
            cyc++;
        end while (pending_res.size() != 0 && cyc < DRAIN_LIMIT);
        repeat (DEPTH + 4) @(posedge i_clk);
        if (pending_res.size() != 0) begin
            $display("%0t: %0d expected beats never arrived", $time, pending_res.size());
            n_err++;
        end

        $display("ran %0d commands incl. %0d traverses; %0d beats checked", n_cmds, n_trav,
                 n_results);
        $display("full-push beats %0d, empty beats %0d, mismatches %0d", n_full, n_empty,
                 n_err);
        if (n_err == 0) begin
            $display("bounded_double_ended_queue_core verification clean");
        end else begin
            $display("bounded_double_ended_queue_core verification failed");
        end
        $finish;
    end

endmodule

FILE: bounded_double_ended_queue_core.f
rtl/core/bdeq_pkg.sv
rtl/core/bdeq_cell.sv
rtl/core/bounded_double_ended_queue_core.sv
bench/bounded_double_ended_queue_core_test.sv
